// ===== rtl/wwf_pkg.sv =====
// ----------------------------------------------------------------------------
// wwf_pkg
// Shared types and constants for the word wrap text formatter.
// ----------------------------------------------------------------------------
package wwf_pkg;

  localparam int WORD_MAX_DEF = 32;
  localparam int LEN_W        = 6;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [5:0] COL_CAP   = 6'd61;
  localparam logic [5:0] SPACE_CAP = 6'd63;
  localparam logic [7:0] TAB_STEP  = 8'd8;
  localparam logic [7:0] TAB_MASK  = ~8'd7;

  localparam logic       REG_LAST_COLUMN = 1'b0;
  localparam logic       REG_LAST_ROW    = 1'b1;
  localparam logic [5:0] LAST_COLUMN_RST = 6'd61;
  localparam logic [7:0] LAST_ROW_RST    = 8'd23;

  // Output schedule for one accepted item
  typedef struct packed {
    logic             nla;     // newline before the word
    logic             full_a;
    logic [5:0]       cnt;     // spaces before the word
    logic [LEN_W-1:0] wcnt;    // word characters
    logic             nlb;     // newline after the word
    logic             full_b;
  } plan_t;

endpackage

// ===== rtl/wwf_word_mem.sv =====
// ----------------------------------------------------------------------------
// wwf_word_mem
// Word buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wwf_word_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wwf_plan.sv =====
// ----------------------------------------------------------------------------
// wwf_plan
// Line state (word length, pending spaces, column, row) and the output
// schedule of each accepted item.
// ----------------------------------------------------------------------------
module wwf_plan #(
  parameter int WORD_MAX = wwf_pkg::WORD_MAX_DEF,
  parameter int AW       = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      opcode,
  input  logic [7:0]      char_code,
  input  logic [5:0]      last_column,
  input  logic [7:0]      last_row,
  output wwf_pkg::plan_t  plan,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output logic [7:0]      mem_wdata
);

  import wwf_pkg::*;

  function automatic logic [8:0] row_step(input logic [7:0] row, input logic [7:0] lr);
    logic [8:0] r;
    r = {1'b0, row} + 9'd1;
    if (r >= {1'b0, lr}) begin
      row_step = {1'b1, 8'd0};
    end else begin
      row_step = {1'b0, r[7:0]};
    end
  endfunction

  logic [LEN_W-1:0] word_length, word_length_next;
  logic [5:0]       pending, pending_next;
  logic [5:0]       column, column_next;
  logic [7:0]       row_count, row_count_next;

  logic       is_sp, is_tab, is_nl, is_blank;
  logic [5:0] lim;
  logic       flush, over, nla, nlb, append;
  logic [7:0] sum;
  logic [8:0] step_a, step_b;
  logic [7:0] row1;
  logic [5:0] col1, ps1;
  logic [7:0] tab_sum, tab_diff;
  logic [5:0] tab_ps;

  assign is_sp    = (char_code == CH_SPACE);
  assign is_tab   = (char_code == CH_TAB);
  assign is_nl    = (char_code == CH_NL);
  assign is_blank = is_sp || is_tab || is_nl;

  assign lim   = (last_column > COL_CAP) ? COL_CAP : last_column;
  assign flush = (word_length != '0) &&
                 (((opcode == OP_CHAR) && is_blank) || (opcode == OP_FLUSH) ||
                  (opcode == OP_END));
  assign sum   = {2'b00, column} + {2'b00, pending} + {2'b00, word_length};
  assign over  = sum > {2'b00, lim};
  assign nla   = flush && over;
  assign nlb   = (opcode == OP_CHAR) && is_nl;

  assign step_a = row_step(row_count, last_row);
  assign row1   = nla ? step_a[7:0] : row_count;
  assign step_b = row_step(row1, last_row);

  assign col1 = flush ? (over ? word_length : sum[5:0]) : column;
  assign ps1  = flush ? 6'd0 : pending;

  // Round up to the next tab stop, then measure from the column
  assign tab_sum  = ({2'b00, col1} + {2'b00, ps1} + TAB_STEP) & TAB_MASK;
  assign tab_diff = tab_sum - {2'b00, col1};
  assign tab_ps   = (tab_diff > {2'b00, SPACE_CAP}) ? SPACE_CAP : tab_diff[5:0];

  assign append = (opcode == OP_CHAR) && !is_blank &&
                  (word_length < LEN_W'(WORD_MAX));

  always_comb begin
    plan.nla    = nla;
    plan.full_a = step_a[8];
    plan.wcnt   = flush ? word_length : '0;
    plan.nlb    = nlb;
    plan.full_b = step_b[8];
    if (flush) begin
      plan.cnt = over ? 6'd0 : pending;
    end else begin
      plan.cnt = (opcode == OP_END) ? pending : 6'd0;
    end
  end

  assign mem_we    = accept && append;
  assign mem_waddr = word_length[AW-1:0];
  assign mem_wdata = char_code;

  always_comb begin
    word_length_next = word_length;
    pending_next     = pending;
    column_next      = column;
    row_count_next   = row_count;
    case (opcode)
      OP_CHAR: begin
        if (is_blank) begin
          word_length_next = '0;
          column_next      = col1;
          row_count_next   = row1;
          if (is_sp) begin
            pending_next = (ps1 < SPACE_CAP) ? ps1 + 6'd1 : SPACE_CAP;
          end else if (is_tab) begin
            pending_next = tab_ps;
          end else begin
            pending_next   = 6'd0;
            column_next    = 6'd0;
            row_count_next = step_b[7:0];
          end
        end else if (append) begin
          word_length_next = word_length + LEN_W'(1);
        end
      end
      OP_FLUSH: begin
        word_length_next = '0;
        pending_next     = ps1;
        column_next      = col1;
        row_count_next   = row1;
      end
      OP_END: begin
        word_length_next = '0;
        pending_next     = 6'd0;
        column_next      = 6'd0;
        row_count_next   = 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      pending     <= 6'd0;
      column      <= 6'd0;
      row_count   <= 8'd0;
    end else if (accept) begin
      word_length <= word_length_next;
      pending     <= pending_next;
      column      <= column_next;
      row_count   <= row_count_next;
    end
  end

endmodule

// ===== rtl/wwf_seq.sv =====
// ----------------------------------------------------------------------------
// wwf_seq
// Output sequencer: walks the schedule of one item (newline or spaces, the
// word from the buffer, trailing newline) into the output register.
// ----------------------------------------------------------------------------
module wwf_seq #(
  parameter int AW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  wwf_pkg::plan_t  plan,
  input  logic [7:0]      rd_data,
  output logic [AW-1:0]   rd_addr,
  output logic            idle,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_full,
  output logic            out_last
);

  import wwf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NLA  = 3'd1;
  localparam logic [2:0] S_SPC  = 3'd2;
  localparam logic [2:0] S_WRD  = 3'd3;
  localparam logic [2:0] S_NLB  = 3'd4;

  logic [2:0]       state, state_next;
  logic [5:0]       cnt, cnt_next;
  logic [LEN_W-1:0] wcnt;
  logic [AW-1:0]    idx, idx_next;
  logic             nlb, full_a, full_b;

  logic       emit;
  logic       word_end;
  logic [2:0] after_word, after_pre;
  logic [7:0] emit_char;
  logic       emit_full, emit_last;

  assign idle     = (state == S_IDLE);
  assign emit     = !idle && (!out_valid || out_ready);
  assign word_end = (LEN_W'(idx) + LEN_W'(1)) == wcnt;

  assign after_word = nlb ? S_NLB : S_IDLE;
  assign after_pre  = (wcnt != '0) ? S_WRD : after_word;

  // Read address is idx_next, so the registered rd_data always matches idx
  assign rd_addr = idx_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    emit_char  = CH_NL;
    emit_full  = 1'b0;
    emit_last  = 1'b0;
    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (start) begin
          cnt_next = plan.cnt;
          if (plan.nla) begin
            state_next = S_NLA;
          end else if (plan.cnt != 6'd0) begin
            state_next = S_SPC;
          end else if (plan.wcnt != '0) begin
            state_next = S_WRD;
          end else if (plan.nlb) begin
            state_next = S_NLB;
          end
        end
      end
      S_NLA: begin
        emit_full = full_a;
        emit_last = (wcnt == '0) && !nlb;
        if (emit) begin
          state_next = after_pre;
        end
      end
      S_SPC: begin
        emit_char = CH_SPACE;
        emit_last = (cnt == 6'd1) && (wcnt == '0) && !nlb;
        if (emit) begin
          cnt_next = cnt - 6'd1;
          if (cnt == 6'd1) begin
            state_next = after_pre;
          end
        end
      end
      S_WRD: begin
        emit_char = rd_data;
        emit_last = word_end && !nlb;
        if (emit) begin
          if (word_end) begin
            idx_next   = '0;
            state_next = after_word;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      S_NLB: begin
        emit_full = full_b;
        emit_last = 1'b1;
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (idle && start) begin
      wcnt   <= plan.wcnt;
      nlb    <= plan.nlb;
      full_a <= plan.full_a;
      full_b <= plan.full_b;
    end
  end

  // Output register: hold until the downstream transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      out_full <= emit_full;
      out_last <= emit_last;
    end
  end

endmodule

// ===== rtl/word_wrap_text_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// word_wrap_text_formatter_unit
// Greedy word wrap for terminal text with tab stops and page-full marking.
//
//   channel  role      tdata           tuser            tlast
//   -------  --------  --------------  ---------------  --------------------
//   s_axis   input     [7:0] char_code [1:0] opcode     -
//   m_axis   output    [7:0] out_char  [0] page_full    last result of item
//   apb      config    reg 0 last_column (0x0), reg 1 last_row (0x4)
//
// An item is taken while the sequencer is idle; its results then leave one
// per cycle from the output register unless downstream stalls, and an item
// without results leaves the sequencer idle. The word buffer read port feeds
// one character per cycle. Downstream stalls hold the output register and
// the sequencer; s_axis_tready is low while results of an item remain to be staged.
// Reset is synchronous and clears line state and the sequencer.
// ----------------------------------------------------------------------------
module word_wrap_text_formatter_unit #(
  parameter int WORD_MAX = wwf_pkg::WORD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tuser,   // [0] page_full
  output logic        m_axis_tlast
);

  import wwf_pkg::*;

  localparam int AW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

  logic [5:0]    last_column;
  logic [7:0]    last_row;
  logic          cfg_write;
  logic          accept;
  plan_t         plan;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          idle;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_column <= LAST_COLUMN_RST;
      last_row    <= LAST_ROW_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_LAST_COLUMN: last_column <= pwdata[5:0];
        REG_LAST_ROW:    last_row    <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LAST_COLUMN: prdata = {26'd0, last_column};
      REG_LAST_ROW:    prdata = {24'd0, last_row};
      default:         prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  wwf_plan #(
    .WORD_MAX (WORD_MAX),
    .AW       (AW)
  ) u_plan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (s_axis_tuser),
    .char_code   (s_axis_tdata),
    .last_column (last_column),
    .last_row    (last_row),
    .plan        (plan),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata)
  );

  wwf_word_mem #(
    .DEPTH (WORD_MAX),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wwf_seq #(
    .AW (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .plan      (plan),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .idle      (idle),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_full  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // page_full only ever marks a newline
  a_full_is_newline: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == CH_NL)
    else $error("page_full on a non-newline result");

  // The input side reopens only once the final result of an item is staged
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
    else $error("input reopened before last result was staged");

  // A wrap newline replaces the pending spaces
  a_wrap_no_spaces: assert property (@(posedge clk) disable iff (rst)
    accept && plan.nla |-> plan.cnt == 6'd0)
    else $error("wrap newline scheduled together with spaces");

endmodule
